### src/decimal_square_root_digits_core_assert.svh
// assertion macros for the decimal square root core checker
`ifndef DECIMAL_SQUARE_ROOT_DIGITS_CORE_ASSERT_SVH
`define DECIMAL_SQUARE_ROOT_DIGITS_CORE_ASSERT_SVH

`define DSRD_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`define DSRD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define DSRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/dsrd_pkg.sv
// shared constants and types of the decimal square root core
package dsrd_pkg;

    localparam int LIMB_BITS               = 16;
    localparam int DEF_MAX_FRACTION_DIGITS = 32;
    localparam int DEF_LIMB_COUNT          = 16;
    localparam int CFG_W                   = 6;
    localparam int RADICAND_W              = 64;
    localparam int VALUE_W                 = 32;
    localparam int ROOT_STEPS              = 32;
    localparam logic [CFG_W-1:0] FRACTION_DIGITS_RESET = 6'd30;
    localparam logic [3:0] DIGIT_MAX       = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_LOAD,
        ST_INT,
        ST_TRIAL,
        ST_UPDATE,
        ST_DIGIT
    } dsrd_state_t;

endpackage

### src/decimal_square_root_digits_core.sv
// decimal square root core: integer root then decimal fraction digits
// One radicand is taken while s_tready is high; the core then stays busy until its last
// result transfers. The integer root is found bit pair by bit pair with a shared 65-bit
// subtract/compare, the root and remainder are then loaded into limbs, and the integer
// result is offered. Each fraction digit is found with one 16-bit limb slice processed
// per cycle: every trial digit (9 down to the chosen one, at most ten) is one pass over
// all LIMB_COUNT limbs, the remainder and root update is one more pass, and the digit is
// then offered.
module decimal_square_root_digits_core #(
    parameter int MAX_FRACTION_DIGITS = dsrd_pkg::DEF_MAX_FRACTION_DIGITS,
    parameter int LIMB_COUNT          = dsrd_pkg::DEF_LIMB_COUNT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsrd_pkg::CFG_W-1:0]     cfg_data,      // fraction_digits
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dsrd_pkg::RADICAND_W-1:0] s_tdata,      // radicand
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dsrd_pkg::VALUE_W-1:0]   m_tdata,       // value
    output logic                           m_tuser,       // is_fraction
    output logic                           m_tlast
);
    import dsrd_pkg::*;

    localparam int IDX_W  = $clog2(LIMB_COUNT);
    localparam int WIDE_W = LIMB_COUNT * LIMB_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LIMB_COUNT - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [CFG_W-1:0] MAX_DIGITS = CFG_W'(MAX_FRACTION_DIGITS);

    dsrd_state_t state_reg, state_next;

    logic [CFG_W-1:0]      frac_reg;
    logic [CFG_W-1:0]      want_reg, want_next;
    logic [CFG_W-1:0]      done_reg, done_next;
    logic [63:0]           op_reg, op_next;
    logic [63:0]           res_reg, res_next;
    logic [4:0]            step_reg, step_next;
    logic                  perfect_reg, perfect_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [3:0]            digit_reg, digit_next;
    logic [3:0]            ac_reg, ac_next;
    logic [3:0]            mc_reg, mc_next;
    logic                  gt_reg, gt_next;
    logic                  bw_reg, bw_next;
    logic [6:0]            pc_reg, pc_next;
    logic [4:0]            ac2_reg, ac2_next;
    logic [3:0]            qc_reg, qc_next;

    logic [LIMB_BITS-1:0]  root_limbs [LIMB_COUNT];
    logic [LIMB_BITS-1:0]  rem_limbs  [LIMB_COUNT];

    logic                  in_xfer, out_xfer;
    logic [63:0]           one_bit;
    logic [64:0]           root_trial;
    logic                  root_ge;
    logic [63:0]           root_load, rem_load;
    logic [WIDE_W-1:0]     root_wide, rem_wide;
    logic [LIMB_BITS-1:0]  u_limb, v_limb;
    logic [16:0]           sum_t;
    logic [19:0]           prod_t;
    logic [LIMB_BITS-1:0]  trial_limb;
    logic                  gt_limb;
    logic [16:0]           diff_v;
    logic [22:0]           prod_v;
    logic [16:0]           sum_u;
    logic [19:0]           prod_u;
    logic                  digit_last;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // shared root step unit
    assign one_bit    = 64'd1 << (6'd62 - {step_reg, 1'b0});
    assign root_trial = {1'b0, res_reg} + {1'b0, one_bit};
    assign root_ge    = {1'b0, op_reg} >= root_trial;

    assign root_load = {res_reg[59:0], 4'b0} + {res_reg[61:0], 2'b0};
    assign rem_load  = {op_reg[57:0], 6'b0} + {op_reg[58:0], 5'b0} + {op_reg[61:0], 2'b0};
    assign root_wide = WIDE_W'(root_load);
    assign rem_wide  = WIDE_W'(rem_load);

    // shared limb unit
    assign u_limb     = root_limbs[idx_reg];
    assign v_limb     = rem_limbs[idx_reg];
    assign sum_t      = {1'b0, u_limb} + {13'b0, ac_reg};
    assign prod_t     = {4'b0, sum_t[15:0]} * {16'b0, digit_reg} + {16'b0, mc_reg};
    assign trial_limb = prod_t[15:0];
    assign gt_limb    = (trial_limb > v_limb) || ((trial_limb == v_limb) && gt_reg);
    assign diff_v     = {1'b0, v_limb} - {1'b0, trial_limb} - {16'b0, bw_reg};
    assign prod_v     = {7'b0, diff_v[15:0]} * 23'd100 + {16'b0, pc_reg};
    assign sum_u      = {1'b0, u_limb} + {12'b0, ac2_reg};
    assign prod_u     = {4'b0, sum_u[15:0]} * 20'd10 + {16'b0, qc_reg};

    assign digit_last = (done_reg + 6'd1) == want_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (step_reg == 5'(ROOT_STEPS - 1)) state_next = ST_LOAD;
            end
            ST_LOAD: state_next = ST_INT;
            ST_INT: begin
                if (out_xfer) state_next = m_tlast ? ST_IDLE : ST_TRIAL;
            end
            ST_TRIAL: begin
                if (idx_reg == IDX_LAST && !(digit_reg != 4'd0 && gt_limb)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (idx_reg == IDX_LAST) state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (out_xfer) state_next = m_tlast ? ST_IDLE : ST_TRIAL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        want_next    = want_reg;
        done_next    = done_reg;
        op_next      = op_reg;
        res_next     = res_reg;
        step_next    = step_reg;
        perfect_next = perfect_reg;
        idx_next     = idx_reg;
        digit_next   = digit_reg;
        ac_next      = ac_reg;
        mc_next      = mc_reg;
        gt_next      = gt_reg;
        bw_next      = bw_reg;
        pc_next      = pc_reg;
        ac2_next     = ac2_reg;
        qc_next      = qc_reg;
        case (state_reg)
            ST_IDLE: begin
                op_next   = s_tdata;
                res_next  = 64'd0;
                step_next = 5'd0;
                done_next = 6'd0;
                want_next = (frac_reg > MAX_DIGITS) ? MAX_DIGITS : frac_reg;
            end
            ST_ROOT: begin
                step_next = step_reg + 5'd1;
                if (root_ge) begin
                    op_next  = op_reg - root_trial[63:0];
                    res_next = (res_reg >> 1) + one_bit;
                end else begin
                    res_next = res_reg >> 1;
                end
            end
            ST_LOAD: perfect_next = (op_reg == 64'd0);
            ST_TRIAL: begin
                idx_next = idx_reg + IDX_ONE;
                ac_next  = {3'b0, sum_t[16]};
                mc_next  = prod_t[19:16];
                gt_next  = gt_limb;
                if (idx_reg == IDX_LAST) begin
                    idx_next = '0;
                    mc_next  = 4'd0;
                    gt_next  = 1'b0;
                    if (digit_reg != 4'd0 && gt_limb) begin
                        digit_next = digit_reg - 4'd1;
                        ac_next    = digit_reg - 4'd1;
                    end else begin
                        ac_next  = digit_reg;
                        bw_next  = 1'b0;
                        pc_next  = 7'd0;
                        ac2_next = {digit_reg, 1'b0};
                        qc_next  = 4'd0;
                    end
                end
            end
            ST_UPDATE: begin
                idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_ONE;
                ac_next  = {3'b0, sum_t[16]};
                mc_next  = prod_t[19:16];
                bw_next  = diff_v[16];
                pc_next  = prod_v[22:16];
                ac2_next = {4'b0, sum_u[16]};
                qc_next  = prod_u[19:16];
            end
            ST_INT, ST_DIGIT: begin
                if (out_xfer) begin
                    if (state_reg == ST_DIGIT) done_next = done_reg + 6'd1;
                    idx_next   = '0;
                    digit_next = DIGIT_MAX;
                    ac_next    = DIGIT_MAX;
                    mc_next    = 4'd0;
                    gt_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_INT) || (state_reg == ST_DIGIT);
        m_tuser  = (state_reg == ST_DIGIT);
        if (state_reg == ST_DIGIT) begin
            m_tdata = {28'b0, digit_reg};
            m_tlast = digit_last;
        end else begin
            m_tdata = res_reg[31:0];
            m_tlast = perfect_reg || (want_reg == 6'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            frac_reg  <= FRACTION_DIGITS_RESET;
            done_reg  <= '0;
            digit_reg <= DIGIT_MAX;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) frac_reg <= cfg_data;
            done_reg  <= done_next;
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        want_reg    <= want_next;
        op_reg      <= op_next;
        res_reg     <= res_next;
        step_reg    <= step_next;
        perfect_reg <= perfect_next;
        idx_reg     <= idx_next;
        ac_reg      <= ac_next;
        mc_reg      <= mc_next;
        gt_reg      <= gt_next;
        bw_reg      <= bw_next;
        pc_reg      <= pc_next;
        ac2_reg     <= ac2_next;
        qc_reg      <= qc_next;
        if (state_reg == ST_LOAD) begin
            for (int k = 0; k < LIMB_COUNT; k++) begin
                root_limbs[k] <= root_wide[k*LIMB_BITS +: LIMB_BITS];
                rem_limbs[k]  <= rem_wide[k*LIMB_BITS +: LIMB_BITS];
            end
        end else if (state_reg == ST_UPDATE) begin
            rem_limbs[idx_reg]  <= prod_v[15:0];
            root_limbs[idx_reg] <= prod_u[15:0];
        end
    end

endmodule

### src/dsrd_checker.sv
// port checker for the decimal square root core, bound to the top level
`include "decimal_square_root_digits_core_assert.svh"

module dsrd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dsrd_pkg::VALUE_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import dsrd_pkg::*;

    `DSRD_ASSERT_NEVER(busy_excl, aclk, aresetn, s_tready && m_tvalid, "ready while result pending")
    `DSRD_ASSERT_NEXT(busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready after transfer")
    `DSRD_ASSERT_IMPL(digit_range, aclk, aresetn, m_tvalid && m_tuser, m_tdata <= 32'(DIGIT_MAX), "digit out of range")
    `DSRD_ASSERT_NEXT(out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")

endmodule

bind decimal_square_root_digits_core dsrd_checker u_dsrd_checker (.*);

### tb/sv/tb.sv
// testbench for the decimal square root core: directed and random radicands checked digit by digit
`timescale 1ns / 100ps

class root_digit_scoreboard;
    typedef struct packed {
        logic        is_fraction;
        logic [31:0] value;
        logic        last;
    } root_result_t;

    root_result_t expected_digits[$];
    logic [5:0]   fraction_digits = dsrd_pkg::FRACTION_DIGITS_RESET;
    int           failures = 0;

    function void note_radicand(logic [63:0] radicand);
        logic [31:0]  int_root;
        logic [31:0]  trial_root;
        logic [63:0]  root64;
        logic [63:0]  root_square;
        logic [255:0] partial_root;
        logic [255:0] remainder;
        logic [255:0] trial;
        logic [3:0]   digit;
        int           wanted;
        root_result_t res;
        int_root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial_root = int_root | (32'd1 << b);
            if (64'(trial_root) * 64'(trial_root) <= radicand) int_root = trial_root;
        end
        root64 = 64'(int_root);
        root_square = root64 * root64;
        wanted = (fraction_digits > dsrd_pkg::DEF_MAX_FRACTION_DIGITS) ?
                 dsrd_pkg::DEF_MAX_FRACTION_DIGITS : int'(fraction_digits);
        res.is_fraction = 1'b0;
        res.value = int_root;
        res.last = (root_square == radicand) || (wanted == 0);
        expected_digits.push_back(res);
        if (res.last) return;
        partial_root = 256'(root64) * 256'd20;
        remainder = 256'(radicand - root_square) * 256'd100;
        for (int k = 0; k < wanted; k++) begin
            digit = dsrd_pkg::DIGIT_MAX;
            trial = (partial_root + 256'(digit)) * 256'(digit);
            while (digit > 0 && trial > remainder) begin
                digit--;
                trial = (partial_root + 256'(digit)) * 256'(digit);
            end
            remainder = (remainder - trial) * 256'd100;
            partial_root = (partial_root + 256'(digit) * 256'd2) * 256'd10;
            res.is_fraction = 1'b1;
            res.value = 32'(digit);
            res.last = (k == wanted - 1);
            expected_digits.push_back(res);
        end
    endfunction

    function void check_result(logic is_fraction, logic [31:0] value, logic last);
        root_result_t exp_res;
        if (expected_digits.size() == 0) begin
            $error("unexpected result: is_fraction %0d value %0d last %0d",
                   is_fraction, value, last);
            failures++;
            return;
        end
        exp_res = expected_digits.pop_front();
        if (exp_res.is_fraction !== is_fraction) begin
            $error("is_fraction: expected %0d actual %0d", exp_res.is_fraction, is_fraction);
            failures++;
        end
        if (exp_res.value !== value) begin
            $error("value: expected %0d actual %0d", exp_res.value, value);
            failures++;
        end
        if (exp_res.last !== last) begin
            $error("last: expected %0d actual %0d", exp_res.last, last);
            failures++;
        end
    endfunction

    function int pending();
        return expected_digits.size();
    endfunction
endclass

module tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    root_digit_scoreboard sb = new();
    int burst_left = 0;
    int stall_mode = 0;
    int hold_req = 0;
    int hold_taken = 0;
    int hold_count = 0;

    localparam logic [63:0] CAP_SQUARE = 64'hFFFF_FFFE_0000_0001;

    decimal_square_root_digits_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // receiver stall pattern, with a single long hold-off
    always @(posedge aclk) begin
        if (hold_count > 0) begin
            m_tready <= 1'b0;
            hold_count <= hold_count - 1;
        end else if (hold_req != 0 && hold_taken == 0) begin
            m_tready <= 1'b0;
            hold_count <= 3000;
            hold_taken <= 1;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom % 4) != 0;
                default: m_tready <= ($urandom % 2) != 0;
            endcase
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    task automatic send_radicand(input logic [63:0] radicand);
        logic ready_seen;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= radicand;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        sb.note_radicand(radicand);
    endtask

    task automatic write_fraction_digits(input logic [5:0] digits);
        logic ready_seen;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= digits;
        do begin
            @(negedge aclk);
            ready_seen = cfg_ready;
            @(posedge aclk);
        end while (!ready_seen);
        cfg_valid <= 1'b0;
        sb.fraction_digits = digits;
    endtask

    function automatic logic [63:0] random_radicand();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0, 1: return {$urandom, $urandom};
            2: return 64'($urandom_range(0, 1000));
            3: return 64'(r) * 64'(r);
            4: return 64'(r) * 64'(r) + 64'd1;
            5: return 64'(r | 32'd1) * 64'(r | 32'd1) - 64'd1;
            default: return CAP_SQUARE - 64'd8 + 64'($urandom_range(0, 16));
        endcase
    endfunction

    initial begin
        logic [5:0]  phase_digits[7] = '{6'd0, 6'd1, 6'd63, 6'd3, 6'd32, 6'd8, 6'd17};
        logic [63:0] directed[20] = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd15, 64'd16, 64'd99,
            64'hFFFF_FFFF_FFFF_FFFF, CAP_SQUARE, CAP_SQUARE - 64'd1,
            64'hFFFF_FFFE_0000_0000, 64'hFFFF_FFFC_0000_0004, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000,
            64'h0000_0000_FFFF_FFFF, 64'd1_000_000_007, 64'd10_000_000_000};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) send_radicand(directed[i]);
        foreach (phase_digits[p]) begin
            write_fraction_digits(phase_digits[p]);
            stall_mode = p % 3;
            for (int n = 0; n < 21; n++) begin
                if (p == 3 && n == 4) begin
                    @(negedge aclk);
                    hold_req = 1;
                end
                send_radicand(random_radicand());
            end
        end
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("FAILURE");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/dsrd_pkg.sv
src/decimal_square_root_digits_core.sv
src/dsrd_checker.sv
tb/sv/tb.sv
